### src/length_prefix_deframer_macros.svh
// Assertion macros shared by the length prefix deframer modules.
`ifndef LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/lpd_pkg.sv
// Package: shared widths, result kinds and the queue item type of the deframer.
`timescale 1ns / 1ps
`default_nettype none
package lpd_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 32;
   localparam int HDR_CNT_W   = 2;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Last header byte index (four-byte big-endian header)
   localparam logic [HDR_CNT_W-1:0] HDR_LAST = 2'd3;

   // Result kinds carried through the queue
   localparam logic KIND_EMPTY = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] data;
      logic              last;
   } lpd_item_type;

endpackage
`default_nettype wire

### src/lpd_req_if.sv
// Interface: input byte channel of the deframer.
`timescale 1ns / 1ps
`default_nettype none
interface lpd_req_if
   import lpd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              chunk_end;

   modport source (output valid, output in_byte, output chunk_end, input ready);
   modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface
`default_nettype wire

### src/lpd_rsp_if.sv
// Interface: result channel of the deframer.
`timescale 1ns / 1ps
`default_nettype none
interface lpd_rsp_if
   import lpd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              has_byte;
   logic              last;

   modport source (output valid, output out_byte, output has_byte, output last,
                   input ready);
   modport sink   (input valid, input out_byte, input has_byte, input last,
                   output ready);
endinterface
`default_nettype wire

### src/lpd_front.sv
// Front end: takes input beats, gathers length headers, classifies payload bytes.
`timescale 1ns / 1ps
`default_nettype none
module lpd_front
   import lpd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   lpd_req_if.sink           req_chan,
   input  wire logic         csr_we,
   input  wire logic         csr_wdata,
   output lpd_item_type      q_item,
   output logic              q_valid,
   input  wire logic         q_ready
);
   `include "length_prefix_deframer_macros.svh"

   logic                 bypass_ff, bypass_in;
   logic                 in_payload_ff, in_payload_in;
   logic [HDR_CNT_W-1:0] header_count_ff, header_count_in;
   logic [LEN_W-1:0]     length_shift_ff, length_shift_in;
   logic [LEN_W-1:0]     bytes_left_ff, bytes_left_in;
   logic                 accept;
   logic [LEN_W-1:0]     shift_next;
   logic                 has_result;

   assign req_chan.ready = q_ready;
   assign accept         = req_chan.valid & q_ready;
   assign shift_next     = {length_shift_ff[LEN_W-BYTE_W-1:0], req_chan.in_byte};
   assign q_valid        = accept & has_result;

   // Classify the beat and work out the next deframing state
   always_comb begin
      bypass_in       = csr_we ? csr_wdata : bypass_ff;
      in_payload_in   = in_payload_ff;
      header_count_in = header_count_ff;
      length_shift_in = length_shift_ff;
      bytes_left_in   = bytes_left_ff;
      has_result      = 1'b0;
      q_item.kind     = KIND_BYTE;
      q_item.data     = req_chan.in_byte;
      q_item.last     = 1'b0;
      if (bypass_ff) begin
         has_result  = 1'b1;
         q_item.last = req_chan.chunk_end;
      end else if (!in_payload_ff) begin
         length_shift_in = shift_next;
         if (header_count_ff != HDR_LAST) begin
            header_count_in = header_count_ff + 1'b1;
         end else begin
            header_count_in = '0;
            if (shift_next == '0) begin
               // zero-length frame: one empty marker
               has_result  = 1'b1;
               q_item.kind = KIND_EMPTY;
               q_item.data = '0;
               q_item.last = 1'b1;
            end else begin
               bytes_left_in   = shift_next;
               length_shift_in = '0;
               in_payload_in   = 1'b1;
            end
         end
      end else begin
         has_result    = 1'b1;
         bytes_left_in = bytes_left_ff - 1'b1;
         if (bytes_left_ff == LEN_W'(1)) begin
            q_item.last   = 1'b1;
            in_payload_in = 1'b0;
         end
      end
   end

   // Mode register: written any time the write enable is high
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else begin
         bypass_ff <= bypass_in;
      end
   end

   // Deframing state advances only on accepted beats
   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff   <= 1'b0;
         header_count_ff <= '0;
         length_shift_ff <= '0;
         bytes_left_ff   <= '0;
      end else if (accept) begin
         in_payload_ff   <= in_payload_in;
         header_count_ff <= header_count_in;
         length_shift_ff <= length_shift_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

   `LPD_ASSERT_NOW(a_payload_count, clock, reset, in_payload_ff, bytes_left_ff != '0,
      "payload state with no bytes left")
   `LPD_ASSERT_NOW(a_hdr_idle, clock, reset, header_count_ff != '0, !in_payload_ff,
      "header count moved during payload")
   `LPD_ASSERT_NOW(a_bypass_push, clock, reset, accept && bypass_ff, q_valid,
      "bypass beat produced no result")

endmodule
`default_nettype wire

### src/lpd_queue.sv
// Queue: small register FIFO between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module lpd_queue
   import lpd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lpd_item_type in_item,
   input  wire logic         in_valid,
   output logic              in_ready,
   output lpd_item_type      out_item,
   output logic              out_valid,
   input  wire logic         out_ready
);
   `include "length_prefix_deframer_macros.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lpd_item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage: no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   `LPD_ASSERT_NOW(a_no_overfill, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH),
      "queue count beyond depth")
   `LPD_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop,
      count_ff == $past(count_ff) + 1'b1, "push did not grow the queue")
   `LPD_ASSERT_NEXT(a_pop_shrinks, clock, reset, pop && !push,
      count_ff == $past(count_ff) - 1'b1, "pop did not shrink the queue")

endmodule
`default_nettype wire

### src/lpd_back.sv
// Back end: turns queued results into output beats in a registered stage.
`timescale 1ns / 1ps
`default_nettype none
module lpd_back
   import lpd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lpd_item_type q_item,
   input  wire logic         q_valid,
   output logic              q_ready,
   lpd_rsp_if.source         rsp_chan
);
   `include "length_prefix_deframer_macros.svh"

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              has_byte_ff, has_byte_in;
   logic              last_ff, last_in;
   logic              load;

   // Slot frees when empty or when the receiver takes the beat
   assign q_ready = !valid_ff || rsp_chan.ready;
   assign load    = q_valid & q_ready;

   // Format the result fields from the queued kind
   always_comb begin
      valid_in    = load ? 1'b1 : (valid_ff & !rsp_chan.ready);
      has_byte_in = (q_item.kind == KIND_BYTE);
      out_byte_in = (q_item.kind == KIND_BYTE) ? q_item.data : '0;
      last_in     = q_item.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= out_byte_in;
         has_byte_ff <= has_byte_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.has_byte = has_byte_ff;
   assign rsp_chan.last     = last_ff;

   `LPD_ASSERT_NOW(a_empty_form, clock, reset, valid_ff && !has_byte_ff,
      last_ff && (out_byte_ff == '0), "malformed empty-frame marker")
   `LPD_ASSERT_NEXT(a_load_shows, clock, reset, load, valid_ff,
      "loaded result not presented")
   `LPD_ASSERT_NEXT(a_taken_clears, clock, reset, valid_ff && rsp_chan.ready && !q_valid,
      !valid_ff, "taken beat presented again")

endmodule
`default_nettype wire

### src/length_prefix_deframer.sv
// Top level: length-prefixed frame decoder for a received byte stream.
//
// req_chan carries one stream byte per beat (in_byte, chunk_end). Deframing:
// each frame is a four-byte big-endian length followed by that many payload
// bytes. Header beats give no result; each payload byte comes out on rsp_chan
// with has_byte set and last on the final byte. A zero length gives a single
// beat with has_byte clear, out_byte zero and last set, as soon as the fourth
// header byte is accepted. With csr_wdata written high (csr_we) the block is in
// bypass: every byte passes through and chunk_end becomes last; the frame state
// is held untouched until bypass is cleared.
// A result goes into the queue when its byte is accepted and then passes
// through the registered output stage before it is presented on rsp_chan.
// Throughput: one byte per cycle while the queue has room, set by the
// per-byte header shift and 32-bit byte countdown in the front end; a short
// queue and a registered output stage follow it.
// Reset (synchronous) clears bypass, the header and payload counters and the
// queue. When the receiver stalls, the output beat holds, the queue fills and
// req_chan.ready falls once the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module length_prefix_deframer
   import lpd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  wire logic clock,
   input  wire logic reset,
   lpd_req_if.sink   req_chan,
   lpd_rsp_if.source rsp_chan,
   input  wire logic csr_we,
   input  wire logic csr_wdata
);

   lpd_item_type front_item;
   logic         front_valid;
   logic         front_ready;
   lpd_item_type back_item;
   logic         back_valid;
   logic         back_ready;

   lpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_item    (front_item),
      .q_valid   (front_valid),
      .q_ready   (front_ready)
   );

   lpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (front_item),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_item  (back_item),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   lpd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_item   (back_item),
      .q_valid  (back_valid),
      .q_ready  (back_ready),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
